// ----- rtl/core/mae_pkg.sv -----
// Shared constants, codes and control types of the moving average / EMA filter.
// Used by the channel interfaces and every module under rtl/core.
package mae_pkg;

    // Word widths fixed by the data format.
    localparam int SAMPLE_W   = 16;
    localparam int Q15_W      = 16;
    localparam int Q15_SHIFT  = 15;
    localparam int Q15_ONE    = 32768;
    localparam int CFG_IDX_W  = 2;

    // Default delay line length.
    localparam int TAPS_DEFAULT = 8;

    // Register reset values.
    localparam logic [Q15_W-1:0] ALPHA_RESET = Q15_W'(Q15_ONE);
    localparam logic [Q15_W-1:0] BETA_RESET  = '0;
    localparam logic [Q15_W-1:0] COEF_RESET  = Q15_W'(4096);

    // Register indexes of the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_EMA_ALPHA    = 2'd0,
        CFG_EMA_BETA     = 2'd1,
        CFG_AVERAGE_COEF = 2'd2
    } t_cfg_idx;

    // Item actions.
    localparam logic ACT_FILTER = 1'b0;
    localparam logic ACT_CLEAR  = 1'b1;

    // Per-item control handed to the tap chain and the EMA datapath.
    typedef struct packed {
        logic filt;   // a sample word was accepted
        logic clr;    // a clear word was accepted
    } t_item_ctl;

endpackage

// ----- rtl/core/mae_if.sv -----
// Valid/ready channel interfaces of the moving average / EMA filter.
// Depends on mae_pkg for the payload widths.
interface mae_in_if
    import mae_pkg::*;
;
    logic                       valid;
    logic                       ready;
    logic                       action;
    logic signed [SAMPLE_W-1:0] sample;

    modport source (output valid, action, sample, input ready);
    modport sink   (input valid, action, sample, output ready);
endinterface

interface mae_out_if
    import mae_pkg::*;
;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] filtered;

    modport source (output valid, filtered, input ready);
    modport sink   (input valid, filtered, output ready);
endinterface

interface mae_cfg_if
    import mae_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [Q15_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/core/mae_tap_cell.sv -----
// One cell of the sample delay line: holds a single sample.
// Depends on mae_pkg for the sample width and the control struct.
module mae_tap_cell
    import mae_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_item_ctl                  i_ctl,
    input  logic signed [SAMPLE_W-1:0] i_d,
    output logic signed [SAMPLE_W-1:0] o_q
);

    logic signed [SAMPLE_W-1:0] r_q;

    // Take the neighbor's sample on every accepted sample; empty on clear.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clr) begin
            r_q <= '0;
        end else if (i_ctl.filt) begin
            r_q <= i_d;
        end
    end

    assign o_q = r_q;

endmodule

// ----- rtl/core/mae_tap_chain.sv -----
// Row of delay cells with a running sum of their contents.
// Depends on mae_pkg and mae_tap_cell.
module mae_tap_chain
    import mae_pkg::*;
#(
    parameter int TAPS  = TAPS_DEFAULT,
    parameter int SUM_W = SAMPLE_W + $clog2(TAPS)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_item_ctl                  i_ctl,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    output logic signed [SUM_W-1:0]    o_sum
);

    logic signed [SAMPLE_W-1:0] w_tap [TAPS];
    logic signed [SUM_W-1:0]    r_sum;
    logic signed [SUM_W-1:0]    n_sum;

    // Each cell takes its left neighbor; the first cell takes the new sample.
    for (genvar k = 0; k < TAPS; k++) begin : g_cell
        if (k == 0) begin : g_head
            mae_tap_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (i_ctl),
                .i_d     (i_sample),
                .o_q     (w_tap[k])
            );
        end else begin : g_body
            mae_tap_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (i_ctl),
                .i_d     (w_tap[k-1]),
                .o_q     (w_tap[k])
            );
        end
    end

    // The sum gains the new sample and loses the one falling off the end.
    // The true sum always fits SUM_W bits, so wraparound in between is harmless.
    assign n_sum = r_sum + SUM_W'(i_sample) - SUM_W'(w_tap[TAPS-1]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clr) begin
            r_sum <= '0;
        end else if (i_ctl.filt) begin
            r_sum <= n_sum;
        end
    end

    assign o_sum = r_sum;

endmodule

// ----- rtl/core/mae_ema_unit.sv -----
// Scaling, exponential averaging, saturation and the output register.
// Depends on mae_pkg and the mae_out_if interface.
module mae_ema_unit
    import mae_pkg::*;
#(
    parameter int SUM_W = SAMPLE_W + $clog2(TAPS_DEFAULT)
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_item_ctl               i_ctl,
    input  logic signed [SUM_W-1:0] i_sum,
    input  logic [Q15_W-1:0]        i_alpha,
    input  logic [Q15_W-1:0]        i_beta,
    input  logic [Q15_W-1:0]        i_coef,
    output logic                    o_busy,
    mae_out_if.source               o_out
);

    localparam int P1_W  = SUM_W + Q15_W + 1;       // coef * sum
    localparam int AVG_W = P1_W - Q15_SHIFT;        // average, full precision
    localparam int PA_W  = AVG_W + Q15_W + 1;       // alpha * avg
    localparam int PB_W  = SAMPLE_W + Q15_W + 1;    // beta * last output
    localparam int Y_W   = PA_W + 1;                // weighted sum
    localparam int YS_W  = Y_W - Q15_SHIFT;         // after the shift

    localparam logic signed [YS_W-1:0] SAT_MAX = YS_W'(32767);
    localparam logic signed [YS_W-1:0] SAT_MIN = YS_W'(-32768);

    logic                       r_v1;
    logic                       r_v2;
    logic                       r_v3;
    logic                       r_ov;
    logic signed [AVG_W-1:0]    r_avg;
    logic signed [PA_W-1:0]     r_pa;
    logic signed [PB_W-1:0]     r_pb;
    logic signed [SAMPLE_W-1:0] r_last;
    logic signed [SAMPLE_W-1:0] r_out;

    logic signed [P1_W-1:0]     w_prod;
    logic signed [Y_W-1:0]      w_y;
    logic signed [YS_W-1:0]     w_ys;
    logic signed [SAMPLE_W-1:0] w_sat;
    logic                       w_fire;

    // Stage control: one item in flight, stage 3 waits for a free output.
    assign w_fire = r_v3 && (!r_ov || o_out.ready);
    assign o_busy = r_v1 || r_v2 || r_v3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            r_v1 <= i_ctl.filt;
            r_v2 <= r_v1;
            r_v3 <= r_v1 ? 1'b0 : (r_v2 || (r_v3 && !w_fire));
            if (w_fire) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Stage 1: scale the tap sum by the per-tap weight, floor by 2^15.
    assign w_prod = P1_W'($signed({1'b0, i_coef})) * P1_W'(i_sum);

    always_ff @(posedge i_clk) begin
        if (r_v1) begin
            r_avg <= w_prod[P1_W-1:Q15_SHIFT];
        end
    end

    // Stage 2: weight the new average and the previous output.
    always_ff @(posedge i_clk) begin
        if (r_v2) begin
            r_pa <= PA_W'($signed({1'b0, i_alpha})) * PA_W'(r_avg);
            r_pb <= PB_W'($signed({1'b0, i_beta})) * PB_W'(r_last);
        end
    end

    // Stage 3: add, floor by 2^15 and saturate to the sample range.
    assign w_y  = Y_W'(r_pa) + Y_W'(r_pb);
    assign w_ys = w_y[Y_W-1:Q15_SHIFT];

    always_comb begin
        if (w_ys > SAT_MAX) begin
            w_sat = SAMPLE_W'(SAT_MAX);
        end else if (w_ys < SAT_MIN) begin
            w_sat = SAMPLE_W'(SAT_MIN);
        end else begin
            w_sat = w_ys[SAMPLE_W-1:0];
        end
    end

    // The output history feeds the next item; a clear empties it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clr) begin
            r_last <= '0;
        end else if (w_fire) begin
            r_last <= w_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out <= w_sat;
        end
    end

    assign o_out.valid    = r_ov;
    assign o_out.filtered = r_out;

endmodule

// ----- rtl/core/moving_average_ema_filter.sv -----
// Moving average over a delay line of TAPS samples, followed by a Q15
// exponential moving average with a saturated 16-bit output. A sample word
// passes four clocked steps, the first at the edge that accepts it: the
// delay line shift with its running sum, the per-tap weight multiply, the
// alpha and beta multiplies, and the add with saturation into the output
// register. Only one sample is in flight at a time and the next word is
// taken once the result has moved into the output register. A result that
// finds the output register still full waits in the last step and holds
// off the input until the output word is taken. A clear word empties the
// delay line and the output history and gives no result.
// Registers are written through their own port, which is always ready.
module moving_average_ema_filter
    import mae_pkg::*;
#(
    parameter int TAPS = TAPS_DEFAULT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mae_in_if.sink     i_in,
    mae_out_if.source  o_out,
    mae_cfg_if.sink    i_cfg
);

    localparam int SUM_W = SAMPLE_W + $clog2(TAPS);

    logic [Q15_W-1:0]        r_alpha;
    logic [Q15_W-1:0]        r_beta;
    logic [Q15_W-1:0]        r_coef;
    logic signed [SUM_W-1:0] w_sum;
    logic                    w_busy;
    logic                    w_accept;
    t_item_ctl               w_ctl;

    // Configuration registers.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha <= ALPHA_RESET;
            r_beta  <= BETA_RESET;
            r_coef  <= COEF_RESET;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_idx'(i_cfg.index))
                CFG_EMA_ALPHA:    r_alpha <= i_cfg.data;
                CFG_EMA_BETA:     r_beta  <= i_cfg.data;
                CFG_AVERAGE_COEF: r_coef  <= i_cfg.data;
                default:          ;
            endcase
        end
    end

    // Input handshake and item decode.
    assign i_in.ready = !w_busy;
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_ctl.filt = w_accept && (i_in.action == ACT_FILTER);
    assign w_ctl.clr  = w_accept && (i_in.action == ACT_CLEAR);

    mae_tap_chain #(
        .TAPS  (TAPS),
        .SUM_W (SUM_W)
    ) u_chain (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl),
        .i_sample (i_in.sample),
        .o_sum    (w_sum)
    );

    mae_ema_unit #(
        .SUM_W (SUM_W)
    ) u_ema (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_sum   (w_sum),
        .i_alpha (r_alpha),
        .i_beta  (r_beta),
        .i_coef  (r_coef),
        .o_busy  (w_busy),
        .o_out   (o_out)
    );

endmodule

// ----- rtl/core/mae_checker.sv -----
// Port-level checks of the moving average / EMA filter, bound to the top level.
// Depends on mae_pkg for the sample width and action codes.
module mae_checker
    import mae_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                i_in_ready,
    input logic                i_in_action,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input logic [SAMPLE_W-1:0] i_out_filtered
);

    logic w_in_acc;
    assign w_in_acc = i_in_valid && i_in_ready;

    // A waiting output word stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output word dropped while stalled");

    // A waiting output word keeps its value.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_filtered))
        else $error("output word changed while stalled");

    // A sample holds off the next word while it is in flight.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && (i_in_action == ACT_FILTER) |=> !i_in_ready)
        else $error("second word taken while a sample is in flight");

    // Every sample that is taken is followed by a valid output word in view.
    a_sample_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && (i_in_action == ACT_FILTER) |-> ##4 i_out_valid)
        else $error("sample gave no result");

    // A clear creates no output word.
    a_clear_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && (i_in_action == ACT_CLEAR) && !i_out_valid |=> !i_out_valid)
        else $error("clear produced an output word");

endmodule

bind moving_average_ema_filter mae_checker u_mae_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_in_action    (i_in.action),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_out_filtered (o_out.filtered)
);
